// ===== hdl/ofc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_pkg: shared types and constants of the OTP fuse controller
// Register map, masks, item function codes, controller states and the
// command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package ofc_pkg;

  localparam int OFC_FUSE_WORDS   = 4096;
  localparam int OFC_SECTOR_COUNT = 4;
  localparam int OFC_SEEN_WORDS   = 4096;
  localparam int OFC_SEEN_AW      = 12;
  localparam int OFC_WORD_W       = 17;

  localparam logic [15:0] OFC_TICKS_RESET = 16'd250;
  localparam logic [31:0] OFC_START_MAGIC = 32'h5052_4f47;
  localparam logic [31:0] OFC_DIO_MASK    = 32'h0f07_ffff;

  localparam int OFC_ST_BUSY = 0;
  localparam int OFC_ST_PWDN = 1;
  localparam int OFC_ST_FAIL = 3;
  localparam int OFC_GLOBAL_LOCK = 8;

  localparam logic [14:0] ADDR_PWDN     = 15'h4000;
  localparam logic [14:0] ADDR_STATUS   = 15'h4004;
  localparam logic [14:0] ADDR_RST_DLY  = 15'h4008;
  localparam logic [14:0] ADDR_CE_DLY   = 15'h400c;
  localparam logic [14:0] ADDR_RE_DLY   = 15'h4010;
  localparam logic [14:0] ADDR_WS_WIDTH = 15'h4014;
  localparam logic [14:0] ADDR_WS_SETUP = 15'h4018;
  localparam logic [14:0] ADDR_WS_HOLD  = 15'h401c;
  localparam logic [14:0] ADDR_PE_DLY   = 15'h4020;
  localparam logic [14:0] ADDR_PADDR    = 15'h4028;
  localparam logic [14:0] ADDR_PCYCLES  = 15'h402c;
  localparam logic [14:0] ADDR_PDATA_LO = 15'h4030;
  localparam logic [14:0] ADDR_PDATA_HI = 15'h4034;
  localparam logic [14:0] ADDR_PCMD     = 15'h4038;
  localparam logic [14:0] ADDR_PBUSY    = 15'h403c;
  localparam logic [14:0] ADDR_DIO      = 15'h4048;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_IO    = 2'd2,
    FUNC_TICK  = 2'd3
  } ofc_func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PROG_LO,
    ST_PROG_HI
  } ofc_state_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic exec;
    logic prog_lo;
    logic prog_hi;
    logic finish;
  } ofc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_prog;
  } ofc_stat_t;

endpackage
`default_nettype wire

// ===== hdl/ofc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_ctrl: sequencing state machine
// Runs the clearing pass after reset, takes items, and steps the datapath
// through execute and the two-word read-modify-write of a fuse program.
// ----------------------------------------------------------------------------
module ofc_ctrl
  import ofc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire ofc_stat_t stat,
  output ofc_cmd_t       cmd,
  output logic           busy
);

  ofc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = stat.need_prog ? ST_PROG_LO : ST_IDLE;
      end
      ST_PROG_LO: state_nxt = ST_PROG_HI;
      ST_PROG_HI: state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        cmd.finish = !stat.need_prog;
      end
      ST_PROG_LO: cmd.prog_lo = 1'b1;
      ST_PROG_HI: begin
        cmd.prog_hi = 1'b1;
        cmd.finish  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_prog_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROG_LO) |-> ($past(state_r) == ST_EXEC))
    else $error("program sequence entered without execute");
  a_finish_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !cmd.finish)
    else $error("two finishes in a row");
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |=> (state_r != ST_CLEAR))
    else $error("clearing pass re-entered");
`endif

endmodule
`default_nettype wire

// ===== hdl/ofc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ofc_datapath: registers, fuse memory and read-once bitmap
// Holds the register file, io line flags and program countdown, the fuse
// word memory and the read-once bitmap, and the result registers.
// ----------------------------------------------------------------------------
module ofc_datapath
  import ofc_pkg::*;
#(
  parameter int FUSE_WORDS = OFC_FUSE_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ofc_cmd_t    cmd,
  output ofc_stat_t        stat,
  input  wire logic [1:0]  in_func,
  input  wire logic [14:0] in_bus_addr,
  input  wire logic [31:0] in_write_data,
  input  wire logic [3:0]  in_io_index,
  input  wire logic        in_io_level,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic             out_busy_res
);

  localparam int FW_AW     = $clog2(FUSE_WORDS);
  localparam int CLR_WORDS = (FUSE_WORDS > OFC_SEEN_WORDS) ? FUSE_WORDS : OFC_SEEN_WORDS;
  localparam int CLR_AW    = $clog2(CLR_WORDS);

  logic [1:0]  func_r;
  logic [14:0] addr_r;
  logic [31:0] data_r;
  logic [3:0]  io_idx_r;
  logic        io_lvl_r;

  logic [15:0] ticks_r;
  logic [1:0]  pwdn_r, pwdn_nxt;
  logic [3:0]  status_r, status_nxt;
  logic [19:0] rst_dly_r, rst_dly_nxt;
  logic [15:0] ce_dly_r, ce_dly_nxt;
  logic [9:0]  re_dly_r, re_dly_nxt;
  logic [15:0] ws_width_r, ws_width_nxt;
  logic [15:0] ws_setup_r, ws_setup_nxt;
  logic [15:0] ws_hold_r, ws_hold_nxt;
  logic [23:0] pe_dly_r, pe_dly_nxt;
  logic [16:0] paddr_r, paddr_nxt;
  logic [8:0]  pcycles_r, pcycles_nxt;
  logic [31:0] pdata_lo_r, pdata_lo_nxt;
  logic [31:0] pdata_hi_r, pdata_hi_nxt;
  logic [31:0] pcmd_r, pcmd_nxt;
  logic        inprog_r, inprog_nxt;
  logic [31:0] dio_r, dio_nxt;
  logic [8:0]  flags_r, flags_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic [CLR_AW-1:0] clr_cnt_r;

  logic [31:0] fuse_mem_r [FUSE_WORDS];
  logic        seen_mem_r [OFC_SEEN_WORDS];
  logic [31:0] fuse_rdata_r;
  logic        seen_rdata_r;

  logic                   fuse_we;
  logic [FW_AW-1:0]       fuse_wa, fuse_ra;
  logic [31:0]            fuse_wd;
  logic                   seen_we;
  logic [OFC_SEEN_AW-1:0] seen_wa;
  logic                   seen_wd;

  logic [OFC_WORD_W-1:0]  in_word, prog_lo_w, prog_hi_w, clr_word;
  logic                   lo_ok, hi_ok;
  logic [4:0]             prog_sec;
  logic [3:0]             lock_lines;
  logic                   locked;

  logic [1:0]             rd_sec;
  logic                   rd_once;
  logic [OFC_WORD_W-1:0]  rd_word;
  logic [31:0]            rd_val;
  logic                   seen_set;
  ofc_func_t              func;

  assign func      = ofc_func_t'(func_r);
  assign in_word   = {5'd0, in_bus_addr[13:2]};
  assign prog_lo_w = {2'd0, paddr_r[16:2]};
  assign prog_hi_w = prog_lo_w + OFC_WORD_W'(1);
  assign lo_ok     = prog_lo_w < OFC_WORD_W'(FUSE_WORDS);
  assign hi_ok     = prog_hi_w < OFC_WORD_W'(FUSE_WORDS);
  assign clr_word  = OFC_WORD_W'(clr_cnt_r);

  assign prog_sec   = paddr_r[16:12];
  assign lock_lines = flags_r[7:4];
  assign locked     = flags_r[OFC_GLOBAL_LOCK] ||
                      (({1'b0, prog_sec} < 6'(OFC_SECTOR_COUNT)) && (prog_sec[4:2] == 3'd0) &&
                       lock_lines[prog_sec[1:0]]);

  assign rd_sec  = addr_r[13:12];
  assign rd_word = {5'd0, addr_r[13:2]};
  assign rd_once = ({1'b0, rd_sec} < 3'(OFC_SECTOR_COUNT)) && flags_r[rd_sec];

  assign stat.clr_last  = (clr_cnt_r == CLR_AW'(CLR_WORDS - 1));
  assign stat.need_prog = (func == FUNC_TICK) && inprog_r && (cnt_r == 16'd1) && !locked;

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_func;
      addr_r   <= in_bus_addr;
      data_r   <= in_write_data;
      io_idx_r <= in_io_index;
      io_lvl_r <= in_io_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= OFC_TICKS_RESET;
    end else if (cfg_we) begin
      ticks_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr && !stat.clr_last) begin
      clr_cnt_r <= clr_cnt_r + CLR_AW'(1);
    end
  end

  // execute: register file, flags and countdown
  always_comb begin
    pwdn_nxt     = pwdn_r;
    status_nxt   = status_r;
    rst_dly_nxt  = rst_dly_r;
    ce_dly_nxt   = ce_dly_r;
    re_dly_nxt   = re_dly_r;
    ws_width_nxt = ws_width_r;
    ws_setup_nxt = ws_setup_r;
    ws_hold_nxt  = ws_hold_r;
    pe_dly_nxt   = pe_dly_r;
    paddr_nxt    = paddr_r;
    pcycles_nxt  = pcycles_r;
    pdata_lo_nxt = pdata_lo_r;
    pdata_hi_nxt = pdata_hi_r;
    pcmd_nxt     = pcmd_r;
    inprog_nxt   = inprog_r;
    dio_nxt      = dio_r;
    flags_nxt    = flags_r;
    cnt_nxt      = cnt_r;
    rd_val       = '0;
    seen_set     = 1'b0;
    case (func)
      FUNC_READ: begin
        if (!addr_r[14]) begin
          if (rd_once && seen_rdata_r) begin
            rd_val = '1;
          end else begin
            seen_set = rd_once;
            rd_val   = (rd_word < OFC_WORD_W'(FUSE_WORDS)) ? fuse_rdata_r : 32'd0;
          end
        end else begin
          case (addr_r)
            ADDR_PWDN:     rd_val = {pwdn_r[1], 30'd0, pwdn_r[0]};
            ADDR_STATUS:   rd_val = {28'd0, status_r};
            ADDR_RST_DLY:  rd_val = {12'd0, rst_dly_r};
            ADDR_CE_DLY:   rd_val = {16'd0, ce_dly_r};
            ADDR_RE_DLY:   rd_val = {22'd0, re_dly_r};
            ADDR_WS_WIDTH: rd_val = {16'd0, ws_width_r};
            ADDR_WS_SETUP: rd_val = {16'd0, ws_setup_r};
            ADDR_WS_HOLD:  rd_val = {16'd0, ws_hold_r};
            ADDR_PE_DLY:   rd_val = {8'd0, pe_dly_r};
            ADDR_PADDR:    rd_val = {15'd0, paddr_r};
            ADDR_PCYCLES:  rd_val = {23'd0, pcycles_r};
            ADDR_PDATA_LO: rd_val = pdata_lo_r;
            ADDR_PDATA_HI: rd_val = pdata_hi_r;
            ADDR_PCMD:     rd_val = pcmd_r;
            ADDR_PBUSY:    rd_val = {31'd0, inprog_r};
            ADDR_DIO:      rd_val = dio_r;
            default:       rd_val = '0;
          endcase
        end
      end
      FUNC_WRITE: begin
        case (addr_r)
          ADDR_PWDN: begin
            pwdn_nxt                = {data_r[31], data_r[0]};
            status_nxt[OFC_ST_PWDN] = data_r[0];
          end
          ADDR_STATUS:   status_nxt[OFC_ST_FAIL] = 1'b0;
          ADDR_RST_DLY:  rst_dly_nxt  = data_r[19:0];
          ADDR_CE_DLY:   ce_dly_nxt   = data_r[15:0];
          ADDR_RE_DLY:   re_dly_nxt   = data_r[9:0];
          ADDR_WS_WIDTH: ws_width_nxt = data_r[15:0];
          ADDR_WS_SETUP: ws_setup_nxt = data_r[15:0];
          ADDR_WS_HOLD:  ws_hold_nxt  = data_r[15:0];
          ADDR_PE_DLY:   pe_dly_nxt   = data_r[23:0];
          ADDR_PADDR:    paddr_nxt    = data_r[16:0];
          ADDR_PCYCLES:  pcycles_nxt  = data_r[8:0];
          ADDR_PDATA_LO: pdata_lo_nxt = data_r;
          ADDR_PDATA_HI: pdata_hi_nxt = data_r;
          ADDR_PCMD: begin
            pcmd_nxt = data_r;
            if (data_r == OFC_START_MAGIC) begin
              status_nxt[OFC_ST_BUSY] = 1'b1;
              inprog_nxt              = 1'b1;
              cnt_nxt                 = (ticks_r == 16'd0) ? 16'd1 : ticks_r;
            end
          end
          ADDR_DIO: dio_nxt = data_r & OFC_DIO_MASK;
          default:  pcmd_nxt = pcmd_r;
        endcase
      end
      FUNC_IO: begin
        if (io_idx_r <= 4'd8) flags_nxt[io_idx_r] = io_lvl_r;
      end
      FUNC_TICK: begin
        if (inprog_r && (cnt_r != 16'd0)) begin
          cnt_nxt = cnt_r - 16'd1;
          if (cnt_r == 16'd1) begin
            status_nxt[OFC_ST_BUSY] = 1'b0;
            inprog_nxt              = 1'b0;
          end
        end
      end
      default: rd_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwdn_r     <= '0;
      status_r   <= '0;
      rst_dly_r  <= '0;
      ce_dly_r   <= '0;
      re_dly_r   <= '0;
      ws_width_r <= '0;
      ws_setup_r <= '0;
      ws_hold_r  <= '0;
      pe_dly_r   <= '0;
      paddr_r    <= '0;
      pcycles_r  <= '0;
      pdata_lo_r <= '0;
      pdata_hi_r <= '0;
      pcmd_r     <= '0;
      inprog_r   <= 1'b0;
      dio_r      <= '0;
      flags_r    <= '0;
      cnt_r      <= '0;
    end else if (cmd.exec) begin
      pwdn_r     <= pwdn_nxt;
      status_r   <= status_nxt;
      rst_dly_r  <= rst_dly_nxt;
      ce_dly_r   <= ce_dly_nxt;
      re_dly_r   <= re_dly_nxt;
      ws_width_r <= ws_width_nxt;
      ws_setup_r <= ws_setup_nxt;
      ws_hold_r  <= ws_hold_nxt;
      pe_dly_r   <= pe_dly_nxt;
      paddr_r    <= paddr_nxt;
      pcycles_r  <= pcycles_nxt;
      pdata_lo_r <= pdata_lo_nxt;
      pdata_hi_r <= pdata_hi_nxt;
      pcmd_r     <= pcmd_nxt;
      inprog_r   <= inprog_nxt;
      dio_r      <= dio_nxt;
      flags_r    <= flags_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // memory ports
  always_comb begin
    fuse_we = 1'b0;
    fuse_wa = prog_lo_w[FW_AW-1:0];
    fuse_wd = fuse_rdata_r | pdata_lo_r;
    if (cmd.clr) begin
      fuse_we = clr_word < OFC_WORD_W'(FUSE_WORDS);
      fuse_wa = clr_word[FW_AW-1:0];
      fuse_wd = '0;
    end else if (cmd.prog_lo) begin
      fuse_we = lo_ok;
    end else if (cmd.prog_hi) begin
      fuse_we = hi_ok;
      fuse_wa = prog_hi_w[FW_AW-1:0];
      fuse_wd = fuse_rdata_r | pdata_hi_r;
    end
    if (cmd.accept) begin
      fuse_ra = in_word[FW_AW-1:0];
    end else if (cmd.prog_lo) begin
      fuse_ra = prog_hi_w[FW_AW-1:0];
    end else begin
      fuse_ra = prog_lo_w[FW_AW-1:0];
    end
  end

  always_comb begin
    seen_we = 1'b0;
    seen_wa = addr_r[13:2];
    seen_wd = 1'b1;
    if (cmd.clr) begin
      seen_we = clr_word < OFC_WORD_W'(OFC_SEEN_WORDS);
      seen_wa = clr_word[OFC_SEEN_AW-1:0];
      seen_wd = 1'b0;
    end else if (cmd.exec) begin
      seen_we = seen_set;
    end
  end

  always_ff @(posedge clk) begin
    if (fuse_we) fuse_mem_r[fuse_wa] <= fuse_wd;
    fuse_rdata_r <= fuse_mem_r[fuse_ra];
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem_r[seen_wa] <= seen_wd;
    seen_rdata_r <= seen_mem_r[in_bus_addr[13:2]];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_read_data <= rd_val;
      out_busy_res  <= status_nxt[OFC_ST_BUSY];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/otp_fuse_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// otp_fuse_controller_top: OTP fuse array controller
// Register bus reads and writes, io line changes and microsecond ticks
// drive a fuse word memory with read-once sectors and lock lines.
//
//   channel   ports                                   handshake
//   input     in_func in_bus_addr in_write_data        start & !busy
//             in_io_index in_io_level
//   result    out_read_data out_busy_res               out_valid, one cycle
//   config    cfg_data (program_ticks)                 cfg_valid & cfg_ready
//
// An item's fuse memory read is issued at acceptance and its registered
// data is used in the execute cycle; the result strobe is registered from
// that cycle. A tick that expires the countdown adds the program low and
// high steps, a two-word read-modify-write through the fuse memory's
// read and write ports, unless the global or sector lock drops the program.
// After reset a clearing pass over max(FUSE_WORDS, 4096) words blanks the
// fuse memory and the read-once bitmap; busy is high meanwhile and config
// writes are still taken. cfg_ready is always high. Results cannot stall.
// ----------------------------------------------------------------------------
module otp_fuse_controller_top
  import ofc_pkg::*;
#(
  parameter int FUSE_WORDS = OFC_FUSE_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [14:0] in_bus_addr,
  input  wire logic [31:0] in_write_data,
  input  wire logic [3:0]  in_io_index,
  input  wire logic        in_io_level,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic             out_busy_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  ofc_cmd_t  cmd;
  ofc_stat_t stat;

  assign cfg_ready = 1'b1;

  ofc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ofc_datapath #(
    .FUSE_WORDS (FUSE_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_func       (in_func),
    .in_bus_addr   (in_bus_addr),
    .in_write_data (in_write_data),
    .in_io_index   (in_io_index),
    .in_io_level   (in_io_level),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_busy_res  (out_busy_res)
  );

`ifndef ASSERT_OFF
  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work");
`endif

endmodule
`default_nettype wire
